@@ hdl/cpr_pkg.sv @@
// Shared types and constants for the clock page replacement unit.
package cpr_pkg;

  localparam int unsigned CapacityDefault = 64;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_SETPIN = 3'd2;
  localparam logic [2:0] OP_DIRTY  = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_VICTIM = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input beat, clear scan pointer
    logic scan_step;  // read entry at scan pointer, advance it
    logic hand_step;  // victim sweep step at the hand
    logic rescan;     // restart scan from index 0 for unpinned search
    logic apply;      // perform the update for the found entry
    logic move_step;  // second step of remove: fill hole from last
    logic emit;       // drive the result beat
  } cpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;      // current scan entry holds the tag
    logic scan_end;   // scan pointer reached entry count
    logic empty;      // list is empty
    logic ref_set;    // reference bit at the hand is set
    logic lap_done;   // next hand position is its start
    logic unpinned;   // current scan entry is unpinned
    logic [2:0] op;   // captured operation
  } cpr_stat_t;

endpackage

@@ hdl/cpr_ctrl.sv @@
// Controller state machine for the clock page replacement unit.
module cpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cpr_pkg::cpr_stat_t stat,
  output cpr_pkg::cpr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_SWEEP, S_PINSCAN, S_APPLY, S_MOVE, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == cpr_pkg::OP_VICTIM) begin
          state_nxt = stat.empty ? S_EMIT : S_SWEEP;
        end else if (stat.op > cpr_pkg::OP_VICTIM) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = S_APPLY;
        end else if (stat.match) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.hand_step = 1'b1;
        if (!stat.ref_set) begin
          state_nxt = S_EMIT;
        end else if (stat.lap_done) begin
          cmd.rescan = 1'b1;
          state_nxt = S_PINSCAN;
        end
      end
      S_PINSCAN: begin
        if (stat.scan_end || stat.unpinned) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = (stat.op == cpr_pkg::OP_REMOVE && !stat.scan_end) ? S_MOVE : S_EMIT;
      end
      S_MOVE: begin
        cmd.move_step = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !cmd.emit)
    else $error("emit held for two cycles");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> busy)
    else $error("not busy after load");
  a_move_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_step |-> $past(cmd.apply))
    else $error("move without apply");

endmodule

@@ hdl/cpr_dp.sv @@
// Datapath of the clock page replacement unit: tag memory, flag vectors, hand.
module cpr_dp #(
  parameter int unsigned CAPACITY = cpr_pkg::CapacityDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_operation,
  input  logic [31:0]       in_page_id,
  input  logic              in_pin_state,
  input  cpr_pkg::cpr_cmd_t  cmd,
  output cpr_pkg::cpr_stat_t stat,
  output logic              out_valid,
  output logic              out_hit,
  output logic [31:0]       out_result_page,
  output logic              out_result_dirty,
  output logic              out_result_pinned,
  output logic [1:0]        out_status
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // Tag store: one write port and one registered read port. The read address is
  // the next scan pointer, so tag_q holds the entry at scan_r; during the apply
  // step it fetches the last entry instead, for the move of a remove.
  logic [31:0] tag_mem [CAPACITY];
  logic [31:0] tag_q;
  logic [CAPACITY-1:0] ref_r, pin_r, dirty_r;
  logic [CAPACITY-1:0] ref_nxt, pin_nxt, dirty_nxt;
  logic [CW-1:0] count_r;
  logic [IW-1:0] hand_r, start_r, ptr_r, idx_r;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [2:0]  op_r;
  logic [31:0] page_r;
  logic        pin_in_r;
  logic        found_r, swept_r, full_r;
  logic        fdirty_r, fpin_r;
  logic        hit_r, dirty_o_r, pin_o_r;
  logic        hit_nxt, dirty_o_nxt, pin_o_nxt;
  logic [31:0] rpage_r, rpage_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        valid_r;
  logic        ins_ok;
  logic [IW-1:0] scan_idx, last_idx, hand_inc, rd_idx;

  assign scan_idx = scan_r[IW-1:0];
  assign last_idx = IW'(count_r - CW'(1));
  assign hand_inc = (CW'(hand_r) + CW'(1) >= count_r) ? '0 : hand_r + IW'(1);
  assign ins_ok   = cmd.apply && stat.scan_end && (op_r == cpr_pkg::OP_INSERT) &&
                    (count_r < CapC);
  assign rd_idx   = cmd.apply ? last_idx : scan_nxt[IW-1:0];

  assign stat.match    = (scan_r < count_r) && (tag_q == page_r);
  assign stat.scan_end = (scan_r >= count_r);
  assign stat.empty    = (count_r == '0);
  assign stat.ref_set  = ref_r[ptr_r];
  assign stat.lap_done = (hand_inc == start_r);
  assign stat.unpinned = (scan_r < count_r) && !pin_r[scan_idx];
  assign stat.op       = op_r;

  // Scan pointer: point it at the victim when the sweep stops so its tag is read.
  always_comb begin
    scan_nxt = scan_r;
    if (cmd.load) begin
      scan_nxt = '0;
    end else if (cmd.rescan) begin
      scan_nxt = '0;
    end else if (cmd.hand_step && !ref_r[ptr_r]) begin
      scan_nxt = CW'(ptr_r);
    end else if (cmd.scan_step) begin
      scan_nxt = scan_r + CW'(1);
    end
  end

  always_comb begin
    ref_nxt   = ref_r;
    pin_nxt   = pin_r;
    dirty_nxt = dirty_r;
    if (cmd.hand_step) ref_nxt[ptr_r] = 1'b0;
    if (cmd.apply && !stat.scan_end) begin
      case (op_r)
        cpr_pkg::OP_LOOKUP: ref_nxt[scan_idx]   = 1'b1;
        cpr_pkg::OP_SETPIN: pin_nxt[scan_idx]   = pin_in_r;
        cpr_pkg::OP_DIRTY:  dirty_nxt[scan_idx] = 1'b1;
        default: ;
      endcase
    end
    if (ins_ok) begin
      ref_nxt[count_r[IW-1:0]]   = 1'b0;
      pin_nxt[count_r[IW-1:0]]   = 1'b0;
      dirty_nxt[count_r[IW-1:0]] = 1'b0;
    end
    if (cmd.move_step) begin
      ref_nxt[idx_r]      = ref_r[last_idx];
      pin_nxt[idx_r]      = pin_r[last_idx];
      dirty_nxt[idx_r]    = dirty_r[last_idx];
      ref_nxt[last_idx]   = 1'b0;
      pin_nxt[last_idx]   = 1'b0;
      dirty_nxt[last_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= '0;
      pin_r   <= '0;
      dirty_r <= '0;
      count_r <= '0;
      hand_r  <= '0;
      scan_r  <= '0;
      valid_r <= 1'b0;
      found_r <= 1'b0;
      swept_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      ref_r   <= ref_nxt;
      pin_r   <= pin_nxt;
      dirty_r <= dirty_nxt;
      scan_r  <= scan_nxt;
      if (cmd.load) begin
        op_r     <= in_operation;
        page_r   <= in_page_id;
        pin_in_r <= in_pin_state;
        found_r  <= 1'b0;
        swept_r  <= 1'b0;
        if (CW'(hand_r) >= count_r) begin
          hand_r  <= '0;
          start_r <= '0;
          ptr_r   <= '0;
        end else begin
          start_r <= hand_r;
          ptr_r   <= hand_r;
        end
      end
      if (cmd.hand_step) begin
        hand_r <= hand_inc;
        ptr_r  <= hand_inc;
        if (!ref_r[ptr_r]) found_r <= 1'b1;
      end
      // Every bit was set and the sweep cleared it; search for first unpinned.
      if (cmd.rescan) swept_r <= 1'b1;
      if (cmd.apply) begin
        idx_r    <= scan_idx;
        found_r  <= !stat.scan_end;
        full_r   <= stat.scan_end && (count_r >= CapC);
        fdirty_r <= stat.scan_end ? 1'b0 :
                    (op_r == cpr_pkg::OP_DIRTY) ? 1'b1 : dirty_r[scan_idx];
        fpin_r   <= stat.scan_end ? 1'b0 :
                    (op_r == cpr_pkg::OP_SETPIN) ? pin_in_r : pin_r[scan_idx];
        if (ins_ok) count_r <= count_r + CW'(1);
      end
      if (cmd.move_step) begin
        count_r <= count_r - CW'(1);
        if (CW'(hand_r) >= count_r - CW'(1)) hand_r <= '0;
      end
    end
  end

  // Tag memory: append on insert, move last into hole on remove.
  always_ff @(posedge clk) begin
    if (ins_ok) begin
      tag_mem[count_r[IW-1:0]] <= page_r;
    end else if (cmd.move_step) begin
      tag_mem[idx_r] <= tag_q;
    end
    tag_q <= tag_mem[rd_idx];
  end

  // Result beat contents.
  always_comb begin
    hit_nxt     = 1'b0;
    rpage_nxt   = page_r;
    dirty_o_nxt = fdirty_r;
    pin_o_nxt   = fpin_r;
    st_nxt      = cpr_pkg::ST_OK;
    if (op_r == cpr_pkg::OP_VICTIM) begin
      if (count_r == '0) begin
        rpage_nxt   = '0;
        st_nxt      = cpr_pkg::ST_EMPTY;
        dirty_o_nxt = 1'b0;
        pin_o_nxt   = 1'b0;
      end else if (found_r || (swept_r && !stat.scan_end)) begin
        hit_nxt     = 1'b1;
        rpage_nxt   = tag_q;
        dirty_o_nxt = dirty_r[scan_idx];
        pin_o_nxt   = pin_r[scan_idx];
      end else begin
        rpage_nxt   = '0;
        st_nxt      = cpr_pkg::ST_NOT_FOUND;
        dirty_o_nxt = 1'b0;
        pin_o_nxt   = 1'b0;
      end
    end else if (op_r > cpr_pkg::OP_VICTIM) begin
      rpage_nxt   = '0;
      st_nxt      = cpr_pkg::ST_NOT_FOUND;
      dirty_o_nxt = 1'b0;
      pin_o_nxt   = 1'b0;
    end else if (found_r) begin
      hit_nxt = 1'b1;
    end else if (op_r == cpr_pkg::OP_INSERT) begin
      if (full_r) st_nxt = cpr_pkg::ST_FULL;
    end else begin
      st_nxt = cpr_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hit_r     <= hit_nxt;
      rpage_r   <= rpage_nxt;
      dirty_o_r <= dirty_o_nxt;
      pin_o_r   <= pin_o_nxt;
      st_r      <= st_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_hit           = hit_r;
  assign out_result_page   = rpage_r;
  assign out_result_dirty  = dirty_o_r;
  assign out_result_pinned = pin_o_r;
  assign out_status        = st_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapC)
    else $error("entry count past capacity");
  a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(hand_r) < count_r) || (hand_r == '0))
    else $error("hand past end of list");
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && hit_r |-> st_r == cpr_pkg::ST_OK)
    else $error("hit with bad status");

endmodule

@@ hdl/clock_page_replacement_unit.sv @@
// Top level of the clock page replacement unit.
// Start beat to result strobe: named ops decode, scan up to the tag (to the entry count
// when absent), apply and emit; remove of a resident tag adds a move step.
// Select victim: decode, sweep and scan steps, emit; worst a full lap, then a scan from 0.
// One item at a time; busy drops as the strobe rises, and the receiver cannot stall.
// Reset (synchronous, rst_n low) empties the list, clears all flags and the hand.
module clock_page_replacement_unit #(
  parameter int unsigned CAPACITY = cpr_pkg::CapacityDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_page_id,
  input  logic        in_pin_state,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_result_page,
  output logic        out_result_dirty,
  output logic        out_result_pinned,
  output logic [1:0]  out_status
);

  cpr_pkg::cpr_cmd_t  cmd;
  cpr_pkg::cpr_stat_t stat;
  logic               start_ok;

  // Ignore a start beat while the unit is busy; only an idle unit takes it.
  assign start_ok = start & ~busy;

  cpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_ok),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  cpr_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_page_id        (in_page_id),
    .in_pin_state      (in_pin_state),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_result_page   (out_result_page),
    .out_result_dirty  (out_result_dirty),
    .out_result_pinned (out_result_pinned),
    .out_status        (out_status)
  );

endmodule
